// File: rtl/core/pgalloc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package pgalloc_pkg;

  localparam int MAX_PAGES  = 1024;
  localparam int MAX_BLOCKS = 4096;

  localparam int ADDR_W      = 32;
  localparam int PAGE_SHIFT  = 12;
  localparam int BLOCK_SHIFT = 10;
  localparam int PAGE_NUM_W  = ADDR_W - PAGE_SHIFT;
  localparam int BLOCK_NUM_W = ADDR_W - BLOCK_SHIFT;
  localparam int SPLIT_W     = PAGE_SHIFT - BLOCK_SHIFT;

  localparam int PAGE_AW     = $clog2(MAX_PAGES);
  localparam int PAGE_CNT_W  = $clog2(MAX_PAGES + 1);
  localparam int BLOCK_AW    = $clog2(MAX_BLOCKS);
  localparam int BLOCK_CNT_W = $clog2(MAX_BLOCKS + 1);

  localparam int FREE_W      = 24;
  localparam int CMD_W       = 3;
  localparam int CFG_IDX_W   = 1;
  localparam int IN_TDATA_W  = 32;
  localparam int OUT_TDATA_W = 64;

  localparam logic [CFG_IDX_W-1:0] REG_REGION_START = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_REGION_END   = 1'b1;

  typedef enum logic [CMD_W-1:0] {
    CMD_INIT     = 3'd0,
    CMD_ALLOC_4K = 3'd1,
    CMD_ALLOC_1K = 3'd2,
    CMD_FREE_4K  = 3'd3,
    CMD_FREE_1K  = 3'd4,
    CMD_QUERY    = 3'd5
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef struct packed {
    logic [FREE_W-1:0] free_bytes;
    status_t           status;
    logic [ADDR_W-1:0] addr;
  } res_t;

  localparam int RES_W     = $bits(res_t);
  localparam int OUT_PAD_W = OUT_TDATA_W - RES_W;

endpackage

`default_nettype wire

// File: rtl/core/pgalloc_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module pgalloc_ram #(
  parameter int WIDTH = 20,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// File: rtl/core/pgalloc_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module pgalloc_ctrl
  import pgalloc_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   cfg_we,
  input  wire logic [CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [ADDR_W-1:0]      cfg_data,
  input  wire logic                   cmd_valid,
  output logic                        cmd_ready,
  input  wire logic [CMD_W-1:0]       cmd,
  input  wire logic [ADDR_W-1:0]      cmd_addr,
  output logic                        res_valid,
  input  wire logic                   res_ready,
  output res_t                        res,
  output logic                        pg_we,
  output logic [PAGE_AW-1:0]          pg_waddr,
  output logic [PAGE_NUM_W-1:0]       pg_wdata,
  output logic [PAGE_AW-1:0]          pg_raddr,
  input  wire logic [PAGE_NUM_W-1:0]  pg_rdata,
  output logic                        bk_we,
  output logic [BLOCK_AW-1:0]         bk_waddr,
  output logic [BLOCK_NUM_W-1:0]      bk_wdata,
  output logic [BLOCK_AW-1:0]         bk_raddr,
  input  wire logic [BLOCK_NUM_W-1:0] bk_rdata
);

  localparam int SUM_W = ((BLOCK_CNT_W + BLOCK_SHIFT) > (PAGE_CNT_W + PAGE_SHIFT) ?
                          (BLOCK_CNT_W + BLOCK_SHIFT) : (PAGE_CNT_W + PAGE_SHIFT)) + 1;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_INIT  = 5'b00010,
    S_READ  = 5'b00100,
    S_SPLIT = 5'b01000,
    S_DONE  = 5'b10000
  } state_t;

  typedef enum logic [1:0] {
    RD_PAGE  = 2'd0,
    RD_BLOCK = 2'd1,
    RD_SPLIT = 2'd2
  } rd_kind_t;

  state_t                  state;
  rd_kind_t                rd_kind;
  logic [ADDR_W-1:0]       region_start;
  logic [ADDR_W-1:0]       region_end;
  logic [PAGE_CNT_W-1:0]   page_count;
  logic [BLOCK_CNT_W-1:0]  block_count;
  logic [PAGE_NUM_W:0]     init_page;
  logic [SPLIT_W-1:0]      split_idx;
  logic [PAGE_NUM_W-1:0]   split_page;
  logic [ADDR_W-1:0]       res_addr;
  status_t                 res_status;

  logic                    accept;
  cmd_t                    cmd_code;
  logic                    page_full;
  logic                    page_empty;
  logic                    block_full;
  logic                    block_empty;
  logic                    init_more;
  logic [ADDR_W:0]         start_sum;
  logic [PAGE_NUM_W:0]     init_first;
  logic [PAGE_NUM_W:0]     init_last;
  logic [PAGE_CNT_W-1:0]   page_count_dec;
  logic [BLOCK_CNT_W-1:0]  block_count_dec;
  logic [SUM_W-1:0]        free_sum;

  assign cmd_ready       = (state == S_IDLE);
  assign accept          = cmd_valid && cmd_ready;
  assign cmd_code        = cmd_t'(cmd);
  assign page_full       = (page_count == PAGE_CNT_W'(MAX_PAGES));
  assign page_empty      = (page_count == '0);
  assign block_full      = (block_count == BLOCK_CNT_W'(MAX_BLOCKS));
  assign block_empty     = (block_count == '0);
  assign page_count_dec  = page_count - 1'b1;
  assign block_count_dec = block_count - 1'b1;

  assign start_sum  = {1'b0, region_start} + (ADDR_W + 1)'((1 << PAGE_SHIFT) - 1);
  assign init_first = start_sum[ADDR_W:PAGE_SHIFT];
  assign init_last  = {1'b0, region_end[ADDR_W-1:PAGE_SHIFT]};
  assign init_more  = (init_page < init_last);

  always_comb begin
    pg_we    = 1'b0;
    pg_waddr = page_count[PAGE_AW-1:0];
    pg_wdata = cmd_addr[ADDR_W-1:PAGE_SHIFT];
    pg_raddr = page_count_dec[PAGE_AW-1:0];
    bk_we    = 1'b0;
    bk_waddr = block_count[BLOCK_AW-1:0];
    bk_wdata = cmd_addr[ADDR_W-1:BLOCK_SHIFT];
    bk_raddr = block_count_dec[BLOCK_AW-1:0];
    if (accept && cmd_code == CMD_FREE_4K && !page_full) begin
      pg_we = 1'b1;
    end
    if (accept && cmd_code == CMD_FREE_1K && !block_full) begin
      bk_we = 1'b1;
    end
    if (state == S_INIT && init_more && !page_full) begin
      pg_we    = 1'b1;
      pg_wdata = init_page[PAGE_NUM_W-1:0];
    end
    if (state == S_SPLIT) begin
      bk_we    = 1'b1;
      bk_waddr = BLOCK_AW'(split_idx);
      bk_wdata = {split_page, split_idx};
    end
  end

  always_comb begin
    free_sum = SUM_W'({block_count, {BLOCK_SHIFT{1'b0}}})
             + SUM_W'({page_count, {PAGE_SHIFT{1'b0}}});
  end

  assign res_valid      = (state == S_DONE);
  assign res.addr       = res_addr;
  assign res.status     = res_status;
  assign res.free_bytes = (free_sum > SUM_W'({FREE_W{1'b1}})) ? {FREE_W{1'b1}}
                                                             : free_sum[FREE_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      region_start <= '0;
      region_end   <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_REGION_START: region_start <= cfg_data;
        REG_REGION_END:   region_end   <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      page_count  <= '0;
      block_count <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            res_addr   <= '0;
            res_status <= ST_OK;
            state      <= S_DONE;
            unique case (cmd_code)
              CMD_INIT: begin
                page_count  <= '0;
                block_count <= '0;
                init_page   <= init_first;
                state       <= S_INIT;
              end
              CMD_ALLOC_4K: begin
                if (page_empty) begin
                  res_status <= ST_EMPTY;
                end else begin
                  page_count <= page_count_dec;
                  rd_kind    <= RD_PAGE;
                  state      <= S_READ;
                end
              end
              CMD_ALLOC_1K: begin
                if (!block_empty) begin
                  block_count <= block_count_dec;
                  rd_kind     <= RD_BLOCK;
                  state       <= S_READ;
                end else if (!page_empty) begin
                  page_count <= page_count_dec;
                  rd_kind    <= RD_SPLIT;
                  state      <= S_READ;
                end else begin
                  res_status <= ST_EMPTY;
                end
              end
              CMD_FREE_4K: begin
                if (page_full) begin
                  res_status <= ST_FULL;
                end else begin
                  page_count <= page_count + 1'b1;
                end
              end
              CMD_FREE_1K: begin
                if (block_full) begin
                  res_status <= ST_FULL;
                end else begin
                  block_count <= block_count + 1'b1;
                end
              end
              default: ;
            endcase
          end
        end
        S_INIT: begin
          if (!init_more) begin
            state <= S_DONE;
          end else if (page_full) begin
            res_status <= ST_FULL;
            state      <= S_DONE;
          end else begin
            page_count <= page_count + 1'b1;
            init_page  <= init_page + 1'b1;
          end
        end
        S_READ: begin
          unique case (rd_kind)
            RD_PAGE: begin
              res_addr <= {pg_rdata, {PAGE_SHIFT{1'b0}}};
              state    <= S_DONE;
            end
            RD_BLOCK: begin
              res_addr <= {bk_rdata, {BLOCK_SHIFT{1'b0}}};
              state    <= S_DONE;
            end
            RD_SPLIT: begin
              split_page <= pg_rdata;
              split_idx  <= '0;
              state      <= S_SPLIT;
            end
            default: state <= S_DONE;
          endcase
        end
        S_SPLIT: begin
          if (split_idx == {{(SPLIT_W-1){1'b1}}, 1'b0}) begin
            // The top quarter goes straight out instead of being pushed and popped.
            block_count <= BLOCK_CNT_W'(split_idx) + 1'b1;
            res_addr    <= {split_page, {SPLIT_W{1'b1}}, {BLOCK_SHIFT{1'b0}}};
            state       <= S_DONE;
          end else begin
            split_idx <= split_idx + 1'b1;
          end
        end
        S_DONE: begin
          if (res_ready) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/two_size_page_free_list_allocator.sv
`timescale 1ns / 1ps
`default_nettype none

// Page allocator with a stack of free 4 KiB pages and a stack of free 1 KiB blocks, both
// held in single-port-read synchronous memories. Commands are taken one at a time and each
// returns one result transfer carrying the address, a status and the free byte count.
// Query, free and failed allocations go from idle straight to the result state; allocations
// that read a stack pass through a read state first, since the memories read through a
// register. An alloc1k that must split a page then writes three of its blocks through the
// single write port, as init does one page per step of its walk. The output register
// lets the next command be accepted while a result still waits to be taken.

module two_size_page_free_list_allocator
  import pgalloc_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   cfg_we,
  input  wire logic [CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [ADDR_W-1:0]      cfg_data,
  input  wire logic                   s_tvalid,
  output logic                        s_tready,
  input  wire logic [IN_TDATA_W-1:0]  s_tdata,   // [31:0] address
  input  wire logic [CMD_W-1:0]       s_tuser,   // [2:0] command
  output logic                        m_tvalid,
  input  wire logic                   m_tready,
  output logic [OUT_TDATA_W-1:0]      m_tdata    // [31:0] address_res, [33:32] status,
                                                 // [57:34] free_bytes
);

  logic                   res_valid;
  logic                   res_ready;
  res_t                   res;
  res_t                   out_res;

  logic                   pg_we;
  logic [PAGE_AW-1:0]     pg_waddr;
  logic [PAGE_NUM_W-1:0]  pg_wdata;
  logic [PAGE_AW-1:0]     pg_raddr;
  logic [PAGE_NUM_W-1:0]  pg_rdata;
  logic                   bk_we;
  logic [BLOCK_AW-1:0]    bk_waddr;
  logic [BLOCK_NUM_W-1:0] bk_wdata;
  logic [BLOCK_AW-1:0]    bk_raddr;
  logic [BLOCK_NUM_W-1:0] bk_rdata;

  pgalloc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd_valid (s_tvalid),
    .cmd_ready (s_tready),
    .cmd       (s_tuser),
    .cmd_addr  (s_tdata),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res),
    .pg_we     (pg_we),
    .pg_waddr  (pg_waddr),
    .pg_wdata  (pg_wdata),
    .pg_raddr  (pg_raddr),
    .pg_rdata  (pg_rdata),
    .bk_we     (bk_we),
    .bk_waddr  (bk_waddr),
    .bk_wdata  (bk_wdata),
    .bk_raddr  (bk_raddr),
    .bk_rdata  (bk_rdata)
  );

  pgalloc_ram #(
    .WIDTH (PAGE_NUM_W),
    .DEPTH (MAX_PAGES)
  ) u_page_ram (
    .clk   (clk),
    .we    (pg_we),
    .waddr (pg_waddr),
    .wdata (pg_wdata),
    .raddr (pg_raddr),
    .rdata (pg_rdata)
  );

  pgalloc_ram #(
    .WIDTH (BLOCK_NUM_W),
    .DEPTH (MAX_BLOCKS)
  ) u_block_ram (
    .clk   (clk),
    .we    (bk_we),
    .waddr (bk_waddr),
    .wdata (bk_wdata),
    .raddr (bk_raddr),
    .rdata (bk_rdata)
  );

  assign res_ready = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_ready) begin
      m_tvalid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      out_res <= res;
    end
  end

  assign m_tdata = {{OUT_PAD_W{1'b0}}, out_res};

endmodule

`default_nettype wire

// File: dv/pgalloc_checker.sv
`timescale 1ns / 1ps

module pgalloc_checker
  import pgalloc_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [ADDR_W-1:0]      cfg_data,
  input  logic                   s_tvalid,
  input  logic                   s_tready,
  input  logic [IN_TDATA_W-1:0]  s_tdata,
  input  logic [CMD_W-1:0]       s_tuser,
  input  logic                   m_tvalid,
  input  logic                   m_tready,
  input  logic [OUT_TDATA_W-1:0] m_tdata,
  output int                     fail_count,
  output int                     outstanding,
  output int                     checked
);

  localparam longint unsigned PAGE_BYTES  = 64'h1000;
  localparam longint unsigned BLOCK_BYTES = 64'h400;

  logic [ADDR_W-1:0]      region_start;
  logic [ADDR_W-1:0]      region_end;
  logic [PAGE_NUM_W-1:0]  free_pages [MAX_PAGES];
  int unsigned            n_pages;
  logic [BLOCK_NUM_W-1:0] free_blocks [MAX_BLOCKS];
  int unsigned            n_blocks;

  res_t pending_results[$];
  res_t want;
  res_t got;
  int   fails;
  int   n_checked;

  function automatic bit page_push(input logic [ADDR_W-1:0] addr);
    if (n_pages >= MAX_PAGES) return 1'b0;
    free_pages[n_pages] = addr[ADDR_W-1:PAGE_SHIFT];
    n_pages++;
    return 1'b1;
  endfunction

  function automatic bit block_push(input logic [ADDR_W-1:0] addr);
    if (n_blocks >= MAX_BLOCKS) return 1'b0;
    free_blocks[n_blocks] = addr[ADDR_W-1:BLOCK_SHIFT];
    n_blocks++;
    return 1'b1;
  endfunction

  function automatic bit page_pop(output logic [ADDR_W-1:0] addr);
    addr = '0;
    if (n_pages == 0) return 1'b0;
    n_pages--;
    addr = {free_pages[n_pages], {PAGE_SHIFT{1'b0}}};
    return 1'b1;
  endfunction

  function automatic bit block_pop(output logic [ADDR_W-1:0] addr);
    addr = '0;
    if (n_blocks == 0) return 1'b0;
    n_blocks--;
    addr = {free_blocks[n_blocks], {BLOCK_SHIFT{1'b0}}};
    return 1'b1;
  endfunction

  function automatic res_t next_alloc_result(input logic [CMD_W-1:0] cmd,
                                             input logic [ADDR_W-1:0] addr);
    res_t              r;
    logic [ADDR_W-1:0] taken;
    logic [ADDR_W-1:0] pg;
    longint unsigned   first_pg;
    longint unsigned   last_pg;
    longint unsigned   p;
    longint unsigned   total;
    r.addr   = '0;
    r.status = ST_OK;
    taken    = '0;
    case (cmd)
      CMD_INIT: begin
        first_pg = ({32'b0, region_start} + 64'hFFF) >> PAGE_SHIFT;
        last_pg  = {32'b0, region_end} >> PAGE_SHIFT;
        n_pages  = 0;
        n_blocks = 0;
        for (p = first_pg; p < last_pg; p++) begin
          if (!page_push(ADDR_W'(p << PAGE_SHIFT))) begin
            r.status = ST_FULL;
            break;
          end
        end
      end
      CMD_ALLOC_4K: begin
        if (!page_pop(taken)) r.status = ST_EMPTY;
        r.addr = taken;
      end
      CMD_ALLOC_1K: begin
        // An empty block stack is refilled from one page before the pop.
        if (n_blocks == 0 && page_pop(pg)) begin
          void'(block_push(pg));
          void'(block_push(pg + ADDR_W'(BLOCK_BYTES)));
          void'(block_push(pg + ADDR_W'(2 * BLOCK_BYTES)));
          void'(block_push(pg + ADDR_W'(3 * BLOCK_BYTES)));
        end
        if (!block_pop(taken)) r.status = ST_EMPTY;
        r.addr = taken;
      end
      CMD_FREE_4K: begin
        if (!page_push(addr)) r.status = ST_FULL;
      end
      CMD_FREE_1K: begin
        if (!block_push(addr)) r.status = ST_FULL;
      end
      default: ;
    endcase
    total = longint'(n_blocks) * BLOCK_BYTES + longint'(n_pages) * PAGE_BYTES;
    r.free_bytes = (total > 64'hFFFFFF) ? '1 : total[FREE_W-1:0];
    return r;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      region_start = '0;
      region_end   = '0;
      n_pages      = 0;
      n_blocks     = 0;
      fails        = 0;
      n_checked    = 0;
      pending_results.delete();
    end else begin
      if (cfg_we) begin
        if (cfg_index == REG_REGION_START) region_start = cfg_data;
        if (cfg_index == REG_REGION_END) region_end = cfg_data;
      end
      if (m_tvalid && m_tready) begin
        if (pending_results.size() == 0) begin
          $display("%0t: unexpected result transfer %h", $time, m_tdata);
          fails++;
        end else begin
          want = pending_results.pop_front();
          got  = res_t'(m_tdata[RES_W-1:0]);
          n_checked++;
          if (got.addr !== want.addr) begin
            $display("%0t: address mismatch, expected %h, got %h", $time, want.addr, got.addr);
            fails++;
          end
          if (got.status !== want.status) begin
            $display("%0t: status mismatch, expected %0d, got %0d", $time, want.status,
                     got.status);
            fails++;
          end
          if (got.free_bytes !== want.free_bytes) begin
            $display("%0t: free bytes mismatch, expected %h, got %h", $time,
                     want.free_bytes, got.free_bytes);
            fails++;
          end
          if (m_tdata[OUT_TDATA_W-1:RES_W] !== '0) begin
            $display("%0t: padding mismatch, expected %h, got %h", $time,
                     {OUT_PAD_W{1'b0}}, m_tdata[OUT_TDATA_W-1:RES_W]);
            fails++;
          end
        end
      end
      if (s_tvalid && s_tready) pending_results.push_back(next_alloc_result(s_tuser, s_tdata));
    end
    fail_count  <= fails;
    outstanding <= pending_results.size();
    checked     <= n_checked;
  end

endmodule

// File: dv/tb.sv
`timescale 1ns / 1ps

module tb;
  import pgalloc_pkg::*;

  localparam int STALL_LIMIT = 8000;
  localparam int RAND_PHASES = 6;
  localparam int PHASE_ITEMS = 140;
  localparam int BLOCK_FILL  = 8;
  localparam int IDLE_PCT    = 26;
  localparam logic [CMD_W-1:0] CMD_RSVD_6 = 3'd6;
  localparam logic [CMD_W-1:0] CMD_RSVD_7 = 3'd7;

  logic                   clk;
  logic                   rst;
  logic                   cfg_we;
  logic [CFG_IDX_W-1:0]   cfg_index;
  logic [ADDR_W-1:0]      cfg_data;
  logic                   s_tvalid;
  logic                   s_tready;
  logic [IN_TDATA_W-1:0]  s_tdata;
  logic [CMD_W-1:0]       s_tuser;
  logic                   m_tvalid;
  logic                   m_tready;
  logic [OUT_TDATA_W-1:0] m_tdata;

  int                fail_count;
  int                outstanding;
  int                checked;
  bit                no_idle;
  int                stall_cycles;
  int                cmd_hits [8];
  int                settings;
  logic [ADDR_W-1:0] cur_start;
  logic [ADDR_W-1:0] cur_end;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  two_size_page_free_list_allocator uut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  pgalloc_checker u_check (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tuser    (s_tuser),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .fail_count (fail_count),
    .outstanding(outstanding),
    .checked    (checked)
  );

  always @(negedge clk) begin
    m_tready <= no_idle || ($urandom_range(0, 99) >= IDLE_PCT);
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  task automatic send_item(input logic [CMD_W-1:0] cmd, input logic [ADDR_W-1:0] addr);
    while (!no_idle && $urandom_range(0, 99) < IDLE_PCT) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= cmd;
    s_tdata  <= addr;
    cmd_hits[cmd]++;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic wait_drained();
    s_tvalid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  task automatic write_region(input logic [ADDR_W-1:0] base_addr,
                              input logic [ADDR_W-1:0] limit_addr);
    cfg_we    <= 1'b1;
    cfg_index <= REG_REGION_START;
    cfg_data  <= base_addr;
    @(negedge clk);
    cfg_index <= REG_REGION_END;
    cfg_data  <= limit_addr;
    @(negedge clk);
    cfg_we    <= 1'b0;
    cur_start = base_addr;
    cur_end   = limit_addr;
    settings++;
  endtask

  // Mostly addresses of pages inside the region, with random offset bits.
  function automatic logic [ADDR_W-1:0] pick_free_addr();
    longint unsigned first_pg;
    longint unsigned last_pg;
    longint unsigned pg;
    first_pg = ({32'b0, cur_start} + 64'hFFF) >> PAGE_SHIFT;
    last_pg  = {32'b0, cur_end} >> PAGE_SHIFT;
    if (last_pg > first_pg && $urandom_range(0, 99) < 70) begin
      pg = first_pg + $urandom_range(0, int'(last_pg - first_pg - 1));
      return {pg[PAGE_NUM_W-1:0], 12'($urandom)};
    end
    return $urandom;
  endfunction

  initial begin
    int                unsigned npg;
    int                unsigned r;
    longint unsigned   end64;
    logic [ADDR_W-1:0] base_addr;
    logic [ADDR_W-1:0] limit_addr;
    rst       = 1'b1;
    cfg_we    = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    s_tvalid  = 1'b0;
    s_tdata   = '0;
    s_tuser   = '0;
    m_tready  = 1'b0;
    no_idle   = 1'b0;
    settings  = 1;
    cur_start = '0;
    cur_end   = '0;
    stall_cycles = 0;
    repeat (4) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Empty allocator at its reset region.
    send_item(CMD_QUERY, 32'h0);
    send_item(CMD_ALLOC_4K, 32'h0);
    send_item(CMD_ALLOC_1K, 32'h0);
    send_item(CMD_INIT, 32'hFFFF_FFFF);
    send_item(CMD_RSVD_6, 32'hFFFF_FFFF);
    send_item(CMD_RSVD_7, 32'h0);
    send_item(CMD_FREE_4K, 32'hFFFF_FFFF);
    send_item(CMD_FREE_1K, 32'h0000_0FFF);
    send_item(CMD_FREE_1K, 32'hFFFF_FFFF);
    send_item(CMD_ALLOC_1K, 32'h0);
    send_item(CMD_ALLOC_1K, 32'h0);
    send_item(CMD_ALLOC_1K, 32'h0);
    send_item(CMD_ALLOC_4K, 32'h0);
    send_item(CMD_QUERY, 32'h0);
    wait_drained();

    // Unaligned region of three pages, then splits down to an empty allocator.
    write_region(32'h0000_1001, 32'h0000_5FFF);
    send_item(CMD_INIT, 32'h0);
    send_item(CMD_ALLOC_4K, 32'h0);
    repeat (9) send_item(CMD_ALLOC_1K, 32'h0);
    send_item(CMD_FREE_4K, 32'h1234_5ABC);
    send_item(CMD_ALLOC_4K, 32'h0);
    wait_drained();

    // Start rounding past the top of the address space.
    write_region(32'hFFFF_F001, 32'hFFFF_FFFF);
    send_item(CMD_INIT, 32'h0);
    wait_drained();

    write_region(32'h0002_0000, 32'h0001_0000);
    send_item(CMD_INIT, 32'h0);
    wait_drained();

    // Whole address space: the page stack fills and the rest is dropped.
    write_region(32'h0000_0000, 32'hFFFF_FFFF);
    send_item(CMD_INIT, 32'h0);
    send_item(CMD_FREE_4K, 32'hABCD_E123);
    for (int i = 0; i < BLOCK_FILL; i++) send_item(CMD_FREE_1K, $urandom);
    send_item(CMD_QUERY, 32'h0);
    send_item(CMD_ALLOC_1K, 32'h0);
    send_item(CMD_ALLOC_4K, 32'h0);
    wait_drained();

    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      no_idle = (ph == 1);
      base_addr = (ph == 4) ? 32'($urandom_range(0, 16)) << PAGE_SHIFT : $urandom;
      npg = (ph == 3) ? $urandom_range(1000, 1500) : $urandom_range(0, 40);
      end64 = {32'b0, base_addr} + longint'(npg) * 4096 + $urandom_range(0, 4095);
      limit_addr = (end64 > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : end64[ADDR_W-1:0];
      if (ph == 5) write_region(limit_addr, base_addr);
      else write_region(base_addr, limit_addr);
      send_item(CMD_INIT, 32'h0);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        r = $urandom_range(0, 99);
        if (r < 2) send_item(CMD_INIT, $urandom);
        else if (r < 4) send_item($urandom_range(0, 1) ? CMD_RSVD_6 : CMD_RSVD_7, $urandom);
        else if (r < 24) send_item(CMD_ALLOC_4K, $urandom);
        else if (r < 50) send_item(CMD_ALLOC_1K, $urandom);
        else if (r < 65) send_item(CMD_FREE_4K, pick_free_addr());
        else if (r < 82) send_item(CMD_FREE_1K, pick_free_addr());
        else send_item(CMD_QUERY, $urandom);
      end
      wait_drained();
    end
    no_idle = 1'b0;

    $display("Commands sent: init %0d, alloc4k %0d, alloc1k %0d, free4k %0d, free1k %0d,",
             cmd_hits[CMD_INIT], cmd_hits[CMD_ALLOC_4K], cmd_hits[CMD_ALLOC_1K],
             cmd_hits[CMD_FREE_4K], cmd_hits[CMD_FREE_1K]);
    $display("query %0d, unused codes %0d; %0d region settings, %0d results compared.",
             cmd_hits[CMD_QUERY], cmd_hits[CMD_RSVD_6] + cmd_hits[CMD_RSVD_7], settings,
             checked);
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
